// ===== hdl/gtm_pkg.sv =====
// Shared constants and types for the gamepad turbo / hold modifier.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package gtm_pkg;

    // Slot count and per-slot field widths inside the packed config registers
    localparam int SLOTS     = 8;
    localparam int MODE_W    = 3;
    localparam int BIT_W     = 5;
    localparam int DELAY_W   = 8;
    localparam int BUTTONS_W = 32;
    localparam int TIME_W    = 64;

    // Elapsed milliseconds saturate at this width; any value that large already
    // drains every phase delay to zero
    localparam int ELAPSED_W = DELAY_W + 1;

    // Microsecond difference range handled exactly; beyond it elapsed saturates
    localparam int                 DIFF_W     = 19;
    localparam logic [DIFF_W-1:0]  DIFF_LIMIT = DIFF_W'((2 ** ELAPSED_W) * 1000);

    // Divide by 1000 as a multiply by a rounded-up reciprocal, exact over DIFF_W bits
    localparam int                 RECIP_SHIFT = 29;
    localparam int                 RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(((2 ** RECIP_SHIFT) + 999) / 1000);

    // Slot mode codes; the remaining codes act as off
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAPID     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AUTORAPID = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HOLD      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AUTOHOLD  = 3'd4;

    // Configuration register indexes
    localparam int              CFG_INDEX_W        = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_MODES     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BUTTON    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DELAYS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DELAYS = 8'd3;

    // Per-slot configuration as seen by one slot cell
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BIT_W-1:0]   bitno;
        logic [DELAY_W-1:0] press_delay;
        logic [DELAY_W-1:0] release_delay;
    } slot_cfg_t;

    // Per-sample timing shared by all slots
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 update;
    } tick_t;

endpackage

`default_nettype wire

// ===== hdl/gtm_elapsed.sv =====
// Elapsed-milliseconds unit: (time_us - last_fire_time) / 1000, saturated.
// Depends on gtm_pkg for widths and the reciprocal constant.
`default_nettype none

module gtm_elapsed (
    input  wire logic [gtm_pkg::TIME_W-1:0]    time_us,
    input  wire logic [gtm_pkg::TIME_W-1:0]    last_fire_time,
    output logic      [gtm_pkg::ELAPSED_W-1:0] elapsed
);

    logic [gtm_pkg::TIME_W-1:0]                      diff;
    logic                                            diff_big;
    logic [gtm_pkg::DIFF_W+gtm_pkg::RECIP_W-1:0]     product;

    // Wrapping difference, then check whether it leaves the exact range
    assign diff     = time_us - last_fire_time;
    assign diff_big = (diff[gtm_pkg::TIME_W-1:gtm_pkg::DIFF_W] != '0) ||
                      (diff[gtm_pkg::DIFF_W-1:0] >= gtm_pkg::DIFF_LIMIT);

    // Multiply by the reciprocal and keep the integer part
    assign product = {{gtm_pkg::RECIP_W{1'b0}}, diff[gtm_pkg::DIFF_W-1:0]} *
                     {{gtm_pkg::DIFF_W{1'b0}}, gtm_pkg::RECIP};

    // Saturate at the all-ones code when the difference is out of range
    assign elapsed = diff_big ? {gtm_pkg::ELAPSED_W{1'b1}} :
                     product[gtm_pkg::RECIP_SHIFT +: gtm_pkg::ELAPSED_W];

endmodule

`default_nettype wire

// ===== hdl/gtm_slot.sv =====
// One modifier slot: hold latch, rapid phase timer and the bit rewrite.
// Depends on gtm_pkg for mode codes and the slot_cfg_t / tick_t structs.
`default_nettype none

module gtm_slot (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire gtm_pkg::slot_cfg_t                cfg,
    input  wire gtm_pkg::tick_t                    tick,
    input  wire logic [gtm_pkg::BUTTONS_W-1:0]     word_in,
    output logic      [gtm_pkg::BUTTONS_W-1:0]     word_out,
    output logic                                   fire
);

    logic [gtm_pkg::DELAY_W-1:0]   wait_reg, wait_next;
    logic                          phase_reg, phase_next;
    logic                          hold_en_reg, hold_en_next;
    logic                          seen_reg, seen_next;

    logic [gtm_pkg::BUTTONS_W-1:0] mask;
    logic                          pressed;
    logic [gtm_pkg::ELAPSED_W-1:0] over;
    logic [gtm_pkg::ELAPSED_W-1:0] delay;

    assign mask    = gtm_pkg::BUTTONS_W'(1) << cfg.bitno;
    assign pressed = word_in[cfg.bitno];
    assign over    = tick.elapsed - {1'b0, wait_reg};

    // Work out this slot's state update and its rewrite of the word
    always_comb begin
        word_out     = word_in;
        wait_next    = wait_reg;
        phase_next   = phase_reg;
        hold_en_next = hold_en_reg;
        seen_next    = seen_reg;
        fire         = 1'b0;
        delay        = '0;
        unique case (cfg.mode)
            gtm_pkg::MODE_AUTOHOLD: begin
                word_out = word_in ^ mask;
            end
            gtm_pkg::MODE_HOLD: begin
                // Toggle the latch on a fresh press, forget the press on release
                if (pressed) begin
                    if (!seen_reg) begin
                        hold_en_next = !hold_en_reg;
                        seen_next    = 1'b1;
                    end
                end else begin
                    seen_next = 1'b0;
                end
                if (hold_en_next) begin
                    word_out = word_in | mask;
                end else if (seen_next) begin
                    word_out = word_in ^ mask;
                end
            end
            gtm_pkg::MODE_RAPID, gtm_pkg::MODE_AUTORAPID: begin
                // Flip phase once the wait ran out, carrying the overshoot
                fire = tick.update && (tick.elapsed > {1'b0, wait_reg});
                if (fire) begin
                    phase_next = !phase_reg;
                    delay      = phase_next ? {1'b0, cfg.press_delay}
                                            : {1'b0, cfg.release_delay};
                    wait_next  = (delay > over) ? gtm_pkg::DELAY_W'(delay - over) : '0;
                end
                if ((cfg.mode == gtm_pkg::MODE_AUTORAPID) && pressed) begin
                    word_out = word_in & ~mask;
                end else if ((cfg.mode == gtm_pkg::MODE_AUTORAPID) || pressed) begin
                    word_out = phase_next ? (word_in | mask) : (word_in & ~mask);
                end
            end
            default: begin
            end
        endcase
    end

    // Commit slot state when a sample is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg    <= '0;
            phase_reg   <= 1'b0;
            hold_en_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end else if (advance) begin
            wait_reg    <= wait_next;
            phase_reg   <= phase_next;
            hold_en_reg <= hold_en_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gamepad_turbo_hold_modifier_top.sv =====
// Top level of the gamepad turbo / hold modifier: config registers, input and
// result registers, the elapsed-time unit and the chain of slot cells.
// Depends on gtm_pkg, gtm_elapsed and gtm_slot.
//
// Usage:
//  - Sample requests enter on s_* (valid/ready): button word, microsecond time,
//    update flag and bypass flag. Each request yields exactly one result on m_*.
//  - Configuration requests on cfg_* write slot modes, button indexes, press and
//    release delays; cfg_ready is always high. Indexes past the last register
//    are ignored. Write only while no sample is in flight.
//  - From acceptance to m_valid the request lands in the input register, and the
//    result register loads it once it is free or being drained. One sample can
//    be taken every cycle while results are drained. Updating last_fire_time and
//    the slot state, which the next sample reads, with the result sets that rate.
//  - The slots run combinationally in index order, each seeing the word as the
//    previous slot left it; the elapsed time is taken once per sample.
//  - While m_ready is low the result register holds, and one more sample waits
//    in the input register; s_ready drops only when both are full.
//  - Reset clears the config registers, last_fire_time, all slot state and
//    both valid flags.
`default_nettype none

module gamepad_turbo_hold_modifier_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gtm_pkg::BUTTONS_W-1:0]       s_buttons_in,
    input  wire logic [gtm_pkg::TIME_W-1:0]          s_time_us,
    input  wire logic                                s_is_update,
    input  wire logic                                s_bypass,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [gtm_pkg::BUTTONS_W-1:0]       m_buttons_out,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gtm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [63:0]                         cfg_data
);

    localparam int MODES_W  = gtm_pkg::SLOTS * gtm_pkg::MODE_W;
    localparam int BUTTON_W = gtm_pkg::SLOTS * gtm_pkg::BIT_W;
    localparam int DELAYS_W = gtm_pkg::SLOTS * gtm_pkg::DELAY_W;

    logic [MODES_W-1:0]              slot_modes_reg;
    logic [BUTTON_W-1:0]             slot_button_reg;
    logic [DELAYS_W-1:0]             press_delays_reg;
    logic [DELAYS_W-1:0]             release_delays_reg;

    logic                            in_valid_reg;
    logic [gtm_pkg::BUTTONS_W-1:0]   buttons_reg;
    logic [gtm_pkg::TIME_W-1:0]      time_reg;
    logic                            update_reg;
    logic                            bypass_reg;

    logic                            out_valid_reg;
    logic [gtm_pkg::BUTTONS_W-1:0]   out_buttons_reg;
    logic [gtm_pkg::BUTTONS_W-1:0]   out_buttons_next;

    logic [gtm_pkg::TIME_W-1:0]      last_fire_reg;

    logic                            advance;
    logic                            state_advance;
    logic                            in_take;
    gtm_pkg::tick_t                  tick;
    logic [gtm_pkg::ELAPSED_W-1:0]   elapsed;
    logic [gtm_pkg::SLOTS:0][gtm_pkg::BUTTONS_W-1:0] word_chain;
    logic [gtm_pkg::SLOTS-1:0]       slot_fire;

    // Handshakes: process when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_ready);
    assign state_advance = advance && !bypass_reg;
    assign s_ready       = !in_valid_reg || advance;
    assign in_take       = s_valid && s_ready;
    assign cfg_ready     = 1'b1;
    assign m_valid       = out_valid_reg;
    assign m_buttons_out = out_buttons_reg;

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_modes_reg     <= '0;
            slot_button_reg    <= '0;
            press_delays_reg   <= '0;
            release_delays_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gtm_pkg::REG_SLOT_MODES:     slot_modes_reg     <= cfg_data[MODES_W-1:0];
                gtm_pkg::REG_SLOT_BUTTON:    slot_button_reg    <= cfg_data[BUTTON_W-1:0];
                gtm_pkg::REG_PRESS_DELAYS:   press_delays_reg   <= cfg_data[DELAYS_W-1:0];
                gtm_pkg::REG_RELEASE_DELAYS: release_delays_reg <= cfg_data[DELAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold a request until it is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            buttons_reg <= s_buttons_in;
            time_reg    <= s_time_us;
            update_reg  <= s_is_update;
            bypass_reg  <= s_bypass;
        end
    end

    // Elapsed milliseconds since the last fire, shared by all slots
    gtm_elapsed u_elapsed (
        .time_us        (time_reg),
        .last_fire_time (last_fire_reg),
        .elapsed        (elapsed)
    );

    assign tick.elapsed = elapsed;
    assign tick.update  = update_reg;

    // Slot chain in index order
    assign word_chain[0] = buttons_reg;

    for (genvar g = 0; g < gtm_pkg::SLOTS; g++) begin : g_slot
        gtm_pkg::slot_cfg_t slot_cfg;

        assign slot_cfg.mode          = slot_modes_reg[g*gtm_pkg::MODE_W +: gtm_pkg::MODE_W];
        assign slot_cfg.bitno         = slot_button_reg[g*gtm_pkg::BIT_W +: gtm_pkg::BIT_W];
        assign slot_cfg.press_delay   = press_delays_reg[g*gtm_pkg::DELAY_W +: gtm_pkg::DELAY_W];
        assign slot_cfg.release_delay =
            release_delays_reg[g*gtm_pkg::DELAY_W +: gtm_pkg::DELAY_W];

        gtm_slot u_slot (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (state_advance),
            .cfg      (slot_cfg),
            .tick     (tick),
            .word_in  (word_chain[g]),
            .word_out (word_chain[g+1]),
            .fire     (slot_fire[g])
        );
    end

    // Restart the shared fire time when any slot fired
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fire_reg <= '0;
        end else if (state_advance && (|slot_fire)) begin
            last_fire_reg <= time_reg;
        end
    end

    // Result register: bypass passes the raw word
    assign out_buttons_next = bypass_reg ? buttons_reg : word_chain[gtm_pkg::SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_buttons_reg <= out_buttons_next;
        end
    end

endmodule

`default_nettype wire
